// File: hdl/voxel_column_span_occluder_unit_defines.svh
// Assertion macros for the span occluder.
`ifndef VOXEL_COLUMN_SPAN_OCCLUDER_UNIT_DEFINES_SVH
`define VOXEL_COLUMN_SPAN_OCCLUDER_UNIT_DEFINES_SVH

// Implication checked in the same cycle.
`define VCSO_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define VCSO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/vcso_pkg.sv
package vcso_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  localparam int COL_W    = 9;
  localparam int ROW_W    = 8;
  localparam int HGT_W    = 8;
  localparam int CAM_W    = 10;
  localparam int HOR_W    = 10;
  localparam int PF_W     = 24;
  localparam int DIFF_W   = 11;
  localparam int PROD_W   = 36;
  localparam int FRAC_BITS = 16;
  localparam int CALC_W   = 21;
  localparam int SHADE_SHIFT = 5;
  localparam int ADDR_W   = $clog2(SCREEN_WIDTH);

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic OP_TERRAIN = 1'b0;
  localparam logic OP_SKY     = 1'b1;

  localparam logic KIND_TERRAIN = 1'b0;
  localparam logic KIND_SKY     = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_HEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_ROW   = 1'd1;

  localparam logic [ROW_W-1:0] TOP_EMPTY = ROW_W'(SCREEN_HEIGHT);

  typedef struct packed {
    logic             op;
    logic [COL_W-1:0] column;
    logic [4:0]       base_color;
    logic [2:0]       shade_low;
    logic [2:0]       shade_high;
    logic [3:0]       shade_fraction;
  } item_t;

  typedef struct packed {
    logic             kind;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] rows;
    logic [7:0]       low_pixel;
    logic [7:0]       high_pixel;
    logic [3:0]       dither;
  } span_t;

  typedef struct packed {
    logic              emit;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_data;
    span_t             span;
  } eval_t;

endpackage

// File: hdl/vcso_ram.sv
module vcso_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 320
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/vcso_span_eval.sv
module vcso_span_eval (
  input  vcso_pkg::item_t                      item,
  input  logic signed [vcso_pkg::PROD_W-1:0]   prod,
  input  logic [vcso_pkg::ROW_W-1:0]           top,
  input  logic signed [vcso_pkg::HOR_W-1:0]    horizon,
  output vcso_pkg::eval_t                      ev
);
  import vcso_pkg::*;

  logic                     col_ok;
  logic signed [CALC_W-1:0] row;
  logic signed [CALC_W-1:0] top_ext;
  logic [ROW_W-1:0]         row_c;
  logic                     hit;

  always_comb begin
    col_ok  = (COL_W+1)'(item.column) < (COL_W+1)'(SCREEN_WIDTH);
    // arithmetic shift of the product is the floor division by 2^16
    row     = CALC_W'(horizon) - CALC_W'($signed(prod[PROD_W-1:FRAC_BITS]));
    top_ext = $signed({{(CALC_W-ROW_W){1'b0}}, top});
    row_c   = row[CALC_W-1] ? '0 : row[ROW_W-1:0];
    hit     = (top != '0) && (row < top_ext);

    ev = '0;
    ev.span.column = item.column;
    if (col_ok) begin
      if (item.op == OP_SKY) begin
        ev.wr_en       = 1'b1;
        ev.wr_data     = TOP_EMPTY;
        ev.emit        = top != '0;
        ev.span.kind   = KIND_SKY;
        ev.span.top    = '0;
        ev.span.rows   = top;
      end else begin
        ev.wr_en       = hit;
        ev.wr_data     = row_c;
        ev.emit        = hit;
        ev.span.kind   = KIND_TERRAIN;
        ev.span.top    = row_c;
        ev.span.rows   = top - row_c;
        ev.span.low_pixel  = {item.shade_low, item.base_color};
        ev.span.high_pixel = {item.shade_high, item.base_color};
        ev.span.dither     = item.shade_fraction;
      end
    end
  end

endmodule

// File: hdl/voxel_column_span_occluder_unit.sv
// Voxel column span occluder.
// in_*: one terrain sample or sky flush per transfer; tuser is op, tdata packs
// column, height, base_color, proj_factor, shade_low, shade_high, shade_fraction.
// out_*: one span per transfer; tuser is span_kind, tdata packs span_column,
// span_top, span_rows, low_pixel, high_pixel, dither_fraction.
// cfg_*: register writes (0 camera_height, 1 horizon_row), always ready; write
// only while the block is idle.
// One item per cycle sustained. An item is accepted, its column top is read
// from the top RAM while the projection product is registered; then it is
// evaluated, and once the output register is free it is written back and its
// span loaded into that register, from which the span is offered. A
// back-to-back item on the same column takes the written value through a
// bypass register.
// After reset the top RAM is swept to the screen height, one column a cycle
// over all SCREEN_WIDTH columns, with in_tready low; config writes still go in.
// A stalled receiver holds the output register; the evaluation stage then
// holds any item it has, and in_tready is low while it does, until the span is taken.
`include "voxel_column_span_occluder_unit_defines.svh"

module voxel_column_span_occluder_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // op
  input  logic                                in_tuser,
  // column, height, base_color, proj_factor, shade_low, shade_high,
  // shade_fraction
  input  logic [vcso_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // span_kind
  output logic                                out_tuser,
  // span_column, span_top, span_rows, low_pixel, high_pixel,
  // dither_fraction, 3 zero bits
  output logic [vcso_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vcso_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vcso_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import vcso_pkg::*;

  logic [CAM_W-1:0]         cam_r, cam_nxt;
  logic signed [HOR_W-1:0]  hor_r, hor_nxt;

  logic                     clearing_r, clearing_nxt;
  logic [ADDR_W-1:0]        clr_cnt_r, clr_cnt_nxt;

  logic                     s1_valid_r, s1_valid_nxt;
  item_t                    s1_item_r, s1_item_nxt;
  logic signed [PROD_W-1:0] s1_prod_r, s1_prod_nxt;
  logic                     s1_fwd_r, s1_fwd_nxt;
  logic [ROW_W-1:0]         s1_fwd_data_r, s1_fwd_data_nxt;

  logic                     out_valid_r, out_valid_nxt;
  span_t                    out_span_r, out_span_nxt;

  item_t                    in_item;
  logic [HGT_W-1:0]         in_height;
  logic [PF_W-1:0]          in_pf;
  logic signed [DIFF_W-1:0] diff;
  logic                     in_acc;
  logic                     s1_fire;
  logic [ROW_W-1:0]         top_cur;
  logic [ROW_W-1:0]         ram_rdata;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [ROW_W-1:0]         ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  eval_t                    ev;

  always_comb begin
    in_item.op             = in_tuser;
    in_item.column         = in_tdata[8:0];
    in_height              = in_tdata[16:9];
    in_item.base_color     = in_tdata[21:17];
    in_pf                  = in_tdata[45:22];
    in_item.shade_low      = in_tdata[48:46];
    in_item.shade_high     = in_tdata[51:49];
    in_item.shade_fraction = in_tdata[55:52];
  end

  assign diff = $signed({{(DIFF_W-HGT_W){1'b0}}, in_height})
              - $signed({{(DIFF_W-CAM_W){1'b0}}, cam_r});

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clearing_r && (!s1_valid_r || s1_fire);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // out-of-range columns read entry 0; the evaluation discards them
  assign ram_raddr = ((COL_W+1)'(in_item.column) < (COL_W+1)'(SCREEN_WIDTH))
                   ? ADDR_W'(in_item.column) : '0;
  assign top_cur   = s1_fwd_r ? s1_fwd_data_r : ram_rdata;

  vcso_span_eval u_eval (
    .item    (s1_item_r),
    .prod    (s1_prod_r),
    .top     (top_cur),
    .horizon (hor_r),
    .ev      (ev)
  );

  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = TOP_EMPTY;
    end else begin
      ram_we    = s1_fire && ev.wr_en;
      ram_waddr = ADDR_W'(s1_item_r.column);
      ram_wdata = ev.wr_data;
    end
  end

  vcso_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SCREEN_WIDTH)
  ) u_top_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cam_nxt = cam_r;
    hor_nxt = hor_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CAMERA_HEIGHT: cam_nxt = cfg_data;
        CFG_HORIZON_ROW:   hor_nxt = $signed(cfg_data);
        default: ;
      endcase
    end

    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      if (clr_cnt_r == ADDR_W'(SCREEN_WIDTH - 1)) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
    end

    s1_valid_nxt    = s1_valid_r;
    s1_item_nxt     = s1_item_r;
    s1_prod_nxt     = s1_prod_r;
    s1_fwd_nxt      = s1_fwd_r;
    s1_fwd_data_nxt = s1_fwd_data_r;
    if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      s1_valid_nxt    = 1'b1;
      s1_item_nxt     = in_item;
      s1_prod_nxt     = diff * $signed({1'b0, in_pf});
      // same column written back on this edge: RAM read returns the old top
      s1_fwd_nxt      = s1_fire && ev.wr_en && (s1_item_r.column == in_item.column);
      s1_fwd_data_nxt = ev.wr_data;
    end

    out_valid_nxt = out_valid_r;
    out_span_nxt  = out_span_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_fire && ev.emit) begin
      out_valid_nxt = 1'b1;
      out_span_nxt  = ev.span;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r       <= CAM_W'(90);
      hor_r       <= HOR_W'(90);
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      s1_fwd_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cam_r       <= cam_nxt;
      hor_r       <= hor_nxt;
      clearing_r  <= clearing_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s1_fwd_r    <= s1_fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r     <= s1_item_nxt;
    s1_prod_r     <= s1_prod_nxt;
    s1_fwd_data_r <= s1_fwd_data_nxt;
    out_span_r    <= out_span_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_span_r.kind;
  assign out_tdata  = {3'b000, out_span_r.dither, out_span_r.high_pixel,
                       out_span_r.low_pixel, out_span_r.rows, out_span_r.top,
                       out_span_r.column};

  `VCSO_ASSERT_SAME(a_rows_nonzero, out_valid_r, out_span_r.rows != '0,
                    "span with zero rows")
  `VCSO_ASSERT_SAME(a_span_in_screen, out_valid_r,
                    (ROW_W+1)'(out_span_r.top) + (ROW_W+1)'(out_span_r.rows)
                      <= (ROW_W+1)'(SCREEN_HEIGHT),
                    "span reaches below the screen")
  `VCSO_ASSERT_NEXT(a_fwd_source, in_acc && !(s1_fire && ev.wr_en),
                    !s1_fwd_r, "bypass set without a write-back")

endmodule
